FILE: rtl/btk_pkg.sv
package btk_pkg;

    localparam int CNT_W   = 11;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 24;
    localparam int FUNC_W  = 2;

    // operation codes carried in the func field
    localparam logic [FUNC_W-1:0] FUNC_OFFER = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        left_index;
        logic [INDEX_W-1:0]        right_index;
    } btk_in_t;

    typedef struct packed {
        logic                      accepted;
        logic                      out_valid;
        logic signed [VALUE_W-1:0] out_value;
        logic [INDEX_W-1:0]        out_left;
        logic [INDEX_W-1:0]        out_right;
        logic [CNT_W-1:0]          count_now;
    } btk_out_t;

    // one heap entry as stored in memory
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        left_index;
        logic [INDEX_W-1:0]        right_index;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage

FILE: rtl/btk_ram.sv
module btk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write one entry, read two with registered output
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

FILE: rtl/bounded_top_k_min_heap.sv
// Each operation walks the heap level by level: an offer into a non-full heap sifts up, a
// pop sifts down, an offer into a full heap pops then pushes; clear, no-op and a rejected
// offer walk no levels. Each level is a registered read of the two-read-port heap memory,
// then a compare and write-back. s_ready rises only in idle, the cycle after the result is
// loaded: a new item waits until the last is through, and a stalled result holds it back.
// Reset (aresetn low, synchronous) empties the heap and sets capacity to 1024, memory uncleared.
module bounded_top_k_min_heap #(
    parameter int HEAP_DEPTH = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  btk_pkg::btk_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output btk_pkg::btk_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [10:0]       cfg_data
);

    import btk_pkg::*;

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int PW = ((AW > CNT_W) ? AW : CNT_W) + 1;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_ROOT_CMP  = 8'b0000_0010,
        ST_POP_LATCH = 8'b0000_0100,
        ST_DN_RD     = 8'b0000_1000,
        ST_DN_CMP    = 8'b0001_0000,
        ST_UP_RD     = 8'b0010_0000,
        ST_UP_CMP    = 8'b0100_0000,
        ST_DONE      = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] capacity_reg;
    logic [PW-1:0]    pos_reg, pos_next;
    btk_in_t          item_reg, item_next;
    slot_t            top_reg, top_next;
    slot_t            mov_reg, mov_next;
    logic             acc_reg, acc_next;
    logic             oval_reg, oval_next;
    logic             m_valid_reg, m_valid_next;
    btk_out_t         m_data_reg, m_data_next;

    logic [CNT_W-1:0] cap_eff;
    logic [PW-1:0]    count_ext;
    logic [PW-1:0]    child_l, child_r, parent;
    logic             take_r;
    slot_t            item_slot, ch_slot;
    logic [PW-1:0]    ch_pos;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr, raddr_a, raddr_b;
    slot_t            ram_wdata, rd_a, rd_b;

    function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] p);
        return AW'(p - PW'(1));
    endfunction

    btk_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (HEAP_DEPTH)
    ) u_heap_ram (
        .aclk      (aclk),
        .wr_en     (ram_we),
        .wr_addr   (ram_waddr),
        .wr_data   (ram_wdata),
        .rd_addr_a (raddr_a),
        .rd_data_a (rd_a),
        .rd_addr_b (raddr_b),
        .rd_data_b (rd_b)
    );

    // saturate capacity to the built depth
    assign cap_eff = (32'(capacity_reg) > 32'(HEAP_DEPTH)) ? CNT_W'(HEAP_DEPTH) : capacity_reg;

    assign count_ext = PW'(count_reg);
    assign child_l   = {pos_reg[PW-2:0], 1'b0};
    assign child_r   = {pos_reg[PW-2:0], 1'b1};
    assign parent    = pos_reg >> 1;

    assign item_slot = '{value: item_reg.value, left_index: item_reg.left_index,
                         right_index: item_reg.right_index};

    // pick the smaller child, left on a tie
    assign take_r  = (child_r <= count_ext) && ($signed(rd_b.value) < $signed(rd_a.value));
    assign ch_slot = take_r ? rd_b : rd_a;
    assign ch_pos  = take_r ? child_r : child_l;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // sequencer: each memory level is a read state, then a compare state
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        item_next    = item_reg;
        top_next     = top_reg;
        mov_next     = mov_reg;
        acc_next     = acc_reg;
        oval_next    = oval_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = addr_of(pos_reg);
        ram_wdata    = mov_reg;
        raddr_a      = '0;
        raddr_b      = addr_of(count_ext);

        unique case (state_reg)
            ST_IDLE: begin
                // root and last entry are read here, ready on the next cycle
                if (s_valid) begin
                    item_next = s_data;
                    acc_next  = 1'b0;
                    oval_next = 1'b0;
                    unique case (s_data.func)
                        FUNC_OFFER: begin
                            if (count_reg < cap_eff) begin
                                count_next = count_reg + CNT_W'(1);
                                pos_next   = count_ext + PW'(1);
                                state_next = ST_UP_RD;
                            end else if (count_reg != '0) begin
                                state_next = ST_ROOT_CMP;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end
                        FUNC_POP: begin
                            state_next = (count_reg != '0) ? ST_POP_LATCH : ST_DONE;
                        end
                        FUNC_CLEAR: begin
                            count_next = '0;
                            state_next = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_ROOT_CMP: begin
                // full heap: replace only if strictly above the root
                if ($signed(item_reg.value) > $signed(rd_a.value)) begin
                    top_next   = rd_a;
                    mov_next   = rd_b;
                    count_next = count_reg - CNT_W'(1);
                    pos_next   = PW'(1);
                    state_next = ST_DN_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_POP_LATCH: begin
                top_next   = rd_a;
                mov_next   = rd_b;
                oval_next  = 1'b1;
                count_next = count_reg - CNT_W'(1);
                pos_next   = PW'(1);
                state_next = ST_DN_RD;
            end

            ST_DN_RD: begin
                raddr_a = addr_of(child_l);
                raddr_b = addr_of(child_r);
                if (child_l <= count_ext) begin
                    state_next = ST_DN_CMP;
                end else begin
                    // no child: park the moving entry here
                    ram_we = (count_reg != '0);
                    if (item_reg.func == FUNC_POP) begin
                        state_next = ST_DONE;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                        pos_next   = count_ext + PW'(1);
                        state_next = ST_UP_RD;
                    end
                end
            end

            ST_DN_CMP: begin
                ram_we = 1'b1;
                if ($signed(ch_slot.value) >= $signed(mov_reg.value)) begin
                    // stop: moving entry settles at this level
                    if (item_reg.func == FUNC_POP) begin
                        state_next = ST_DONE;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                        pos_next   = count_ext + PW'(1);
                        state_next = ST_UP_RD;
                    end
                end else begin
                    // lift the child and descend
                    ram_wdata  = ch_slot;
                    pos_next   = ch_pos;
                    state_next = ST_DN_RD;
                end
            end

            ST_UP_RD: begin
                raddr_a = addr_of(parent);
                if (pos_reg > PW'(1)) begin
                    state_next = ST_UP_CMP;
                end else begin
                    ram_we     = 1'b1;
                    ram_wdata  = item_slot;
                    acc_next   = 1'b1;
                    state_next = ST_DONE;
                end
            end

            ST_UP_CMP: begin
                ram_we = 1'b1;
                if ($signed(rd_a.value) <= $signed(item_reg.value)) begin
                    ram_wdata  = item_slot;
                    acc_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    // push the parent down and climb
                    ram_wdata  = rd_a;
                    pos_next   = parent;
                    state_next = ST_UP_RD;
                end
            end

            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.accepted  = acc_reg;
                    m_data_next.out_valid = oval_reg;
                    m_data_next.out_value = oval_reg ? top_reg.value : '0;
                    m_data_next.out_left  = oval_reg ? top_reg.left_index : '0;
                    m_data_next.out_right = oval_reg ? top_reg.right_index : '0;
                    m_data_next.count_now = count_reg;
                    state_next            = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            capacity_reg <= CAP_RESET;
            pos_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                capacity_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        top_reg    <= top_next;
        mov_reg    <= mov_next;
        acc_reg    <= acc_next;
        oval_reg   <= oval_next;
        m_data_reg <= m_data_next;
    end

endmodule

FILE: tb/top_k_heap_checker.sv
module top_k_heap_checker #(
    parameter int DEPTH = 1024
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  btk_pkg::btk_in_t          s_data,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  btk_pkg::btk_out_t         m_data,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [btk_pkg::CNT_W-1:0] cfg_data,
    output int                        mismatch_count,
    output int                        results_pending,
    output int                        results_seen,
    output int                        rejected_offers,
    output int                        empty_pops,
    output int                        peak_fill
);

    import btk_pkg::*;

    // shadow copy of the heap, 1-based like the block's heap positions
    slot_t            heap_mem [1:DEPTH];
    int unsigned      fill;
    logic [CNT_W-1:0] capacity;
    btk_out_t         expected_q [$];

    // push one entry and sift it up; stop at a parent that is not larger
    function automatic void sift_in(slot_t x);
        int unsigned pos;
        int unsigned par;
        fill++;
        pos = fill;
        while (pos > 1) begin
            par = pos >> 1;
            if ($signed(heap_mem[par].value) <= $signed(x.value)) break;
            heap_mem[pos] = heap_mem[par];
            pos = par;
        end
        heap_mem[pos] = x;
    endfunction

    // remove the root; move the last entry down, right child only if strictly smaller
    function automatic slot_t take_min();
        slot_t       top;
        slot_t       mov;
        int unsigned pos;
        int unsigned ch;
        top = heap_mem[1];
        mov = heap_mem[fill];
        pos = 1;
        fill--;
        while ((pos << 1) <= fill) begin
            ch = pos << 1;
            if (ch + 1 <= fill &&
                $signed(heap_mem[ch + 1].value) < $signed(heap_mem[ch].value)) ch++;
            if ($signed(heap_mem[ch].value) >= $signed(mov.value)) break;
            heap_mem[pos] = heap_mem[ch];
            pos = ch;
        end
        if (fill > 0) heap_mem[pos] = mov;
        return top;
    endfunction

    // apply one operation to the shadow heap and form the result beat
    function automatic btk_out_t next_result(btk_in_t op);
        btk_out_t    r;
        slot_t       x;
        slot_t       t;
        int unsigned cap_eff;
        r = '0;
        x.value       = op.value;
        x.left_index  = op.left_index;
        x.right_index = op.right_index;
        cap_eff = (capacity > DEPTH) ? DEPTH : capacity;
        case (op.func)
            FUNC_OFFER: begin
                if (fill < cap_eff) begin
                    sift_in(x);
                    r.accepted = 1'b1;
                end else if (fill > 0 && $signed(x.value) > $signed(heap_mem[1].value)) begin
                    void'(take_min());
                    sift_in(x);
                    r.accepted = 1'b1;
                end
            end
            FUNC_POP: begin
                if (fill > 0) begin
                    t = take_min();
                    r.out_valid = 1'b1;
                    r.out_value = t.value;
                    r.out_left  = t.left_index;
                    r.out_right = t.right_index;
                end
            end
            FUNC_CLEAR: fill = 0;
            default: ;
        endcase
        r.count_now = fill[CNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch in %s of result %0d: expected %h, got %h",
                         name, results_seen, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        btk_out_t want;
        if (!aresetn) begin
            fill            = 0;
            capacity        = CAP_RESET;
            mismatch_count  = 0;
            results_seen    = 0;
            rejected_offers = 0;
            empty_pops      = 0;
            peak_fill       = 0;
            expected_q.delete();
        end else begin
            // register write
            if (cfg_valid && cfg_ready) capacity = cfg_data;

            // predict each accepted input beat
            if (s_valid && s_ready) begin
                want = next_result(s_data);
                if (s_data.func == FUNC_OFFER && !want.accepted) rejected_offers++;
                if (s_data.func == FUNC_POP && !want.out_valid) empty_pops++;
                if (fill > peak_fill) peak_fill = fill;
                expected_q.push_back(want);
            end

            // compare each result beat with the oldest prediction
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d arrived with nothing outstanding: %h",
                                 results_seen, m_data);
                end else begin
                    want = expected_q.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(m_data.accepted));
                    check_field("out_valid", 32'(want.out_valid), 32'(m_data.out_valid));
                    check_field("out_value", want.out_value, m_data.out_value);
                    check_field("out_left", 32'(want.out_left), 32'(m_data.out_left));
                    check_field("out_right", 32'(want.out_right), 32'(m_data.out_right));
                    check_field("count_now", 32'(want.count_now), 32'(m_data.count_now));
                end
            end
        end
        results_pending = expected_q.size();
    end

endmodule

FILE: tb/bounded_top_k_min_heap_tb.sv
module bounded_top_k_min_heap_tb;
    import btk_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
    localparam int CYCLE_LIMIT = 800000;
    localparam int SETTLE_CYCLES = 64;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    btk_in_t          s_data;
    logic             m_valid;
    logic             m_ready;
    btk_out_t         m_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data;

    int mismatch_count;
    int results_pending;
    int results_seen;
    int rejected_offers;
    int empty_pops;
    int peak_fill;

    btk_in_t item_q [$];
    int      burst_left = 0;
    int      gap_left = 0;
    bit      sender_steady = 1'b0;
    int      stall_left = 0;
    int      rx_mode = 0;
    int      cycle_count = 0;
    int      n_offers = 0;
    int      n_pops = 0;
    int      n_clears = 0;
    int      n_nops = 0;

    bounded_top_k_min_heap dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    top_k_heap_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending),
        .results_seen    (results_seen),
        .rejected_offers (rejected_offers),
        .empty_pops      (empty_pops),
        .peak_fill       (peak_fill)
    );

    always #2 aclk = ~aclk;

    // give up on a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("no progress after %0d cycles, %0d results outstanding",
                     cycle_count, results_pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // sender: bursts of beats with random gaps, hold each beat until taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (item_q.size() > 0) begin
                s_data  <= item_q.pop_front();
                s_valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = sender_steady ? 0 : $urandom_range(0, 9);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: periodically pick a new stall pattern: always ready, random ready or stall runs
    always @(posedge aclk) begin
        if (cycle_count % 300 == 0) rx_mode = $urandom_range(0, 2);
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 9) < 6);
                default: begin
                    if ($urandom_range(0, 7) == 0) begin
                        stall_left = $urandom_range(1, 14);
                        m_ready <= 1'b0;
                    end else begin
                        m_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    task automatic queue_item(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] value,
                              logic [INDEX_W-1:0] left, logic [INDEX_W-1:0] right);
        btk_in_t op;
        op.func        = func;
        op.value       = value;
        op.left_index  = left;
        op.right_index = right;
        case (func)
            FUNC_OFFER: n_offers++;
            FUNC_POP:   n_pops++;
            FUNC_CLEAR: n_clears++;
            default:    n_nops++;
        endcase
        item_q.push_back(op);
    endtask

    // scores: extremes, a small pool that forces ties, and plain random
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return VALUE_W'(($urandom_range(0, 6) - 3) * 65536);
            5:       return VALUE_W'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random(int offer_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < offer_pct)
            queue_item(FUNC_OFFER, pick_value(), INDEX_W'($urandom), INDEX_W'($urandom));
        else if (pick < 96)
            queue_item(FUNC_POP, $urandom, INDEX_W'($urandom), INDEX_W'($urandom));
        else if (pick < 98)
            queue_item(FUNC_CLEAR, $urandom, INDEX_W'($urandom), INDEX_W'($urandom));
        else
            queue_item(FUNC_NOP, $urandom, INDEX_W'($urandom), INDEX_W'($urandom));
    endtask

    // wait until every beat is sent and every result is back; returns at a falling edge
    task automatic wait_idle();
        do @(negedge aclk);
        while (item_q.size() != 0 || s_valid || results_pending != 0);
    endtask

    task automatic write_capacity(logic [CNT_W-1:0] cap);
        wait_idle();
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin : stimulus
        int               ph;
        int               k;
        logic [CNT_W-1:0] cap;

        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty heap, unused code, extreme scores and indexes, ties on insert
        queue_item(FUNC_POP, 32'h0, 24'h0, 24'h0);
        queue_item(FUNC_CLEAR, 32'h0, 24'h0, 24'h0);
        queue_item(FUNC_NOP, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        queue_item(FUNC_OFFER, 32'h7FFF_FFFF, 24'hFF_FFFF, 24'h00_0000);
        queue_item(FUNC_OFFER, 32'h8000_0000, 24'h00_0000, 24'hFF_FFFF);
        queue_item(FUNC_OFFER, 32'h0, 24'h5A_5A5A, 24'hA5_A5A5);
        queue_item(FUNC_OFFER, 32'h0, 24'h00_0001, 24'h00_0002);
        queue_item(FUNC_OFFER, 32'h0001_0000, 24'h00_0003, 24'h00_0004);
        repeat (6) queue_item(FUNC_POP, 32'h0, 24'h0, 24'h0);

        // capacity zero rejects everything
        write_capacity(11'd0);
        queue_item(FUNC_OFFER, 32'h0005_0000, 24'h00_0010, 24'h00_0011);

        // full heap: replace the root, reject a score equal to the root
        write_capacity(11'd3);
        queue_item(FUNC_OFFER, 32'h0003_0000, 24'h00_0020, 24'h00_0021);
        queue_item(FUNC_OFFER, 32'h0001_0000, 24'h00_0022, 24'h00_0023);
        queue_item(FUNC_OFFER, 32'h0002_0000, 24'h00_0024, 24'h00_0025);
        queue_item(FUNC_OFFER, 32'h0004_0000, 24'h00_0026, 24'h00_0027);
        queue_item(FUNC_OFFER, 32'h0002_0000, 24'h00_0028, 24'h00_0029);

        // capacity below the fill count keeps every entry
        write_capacity(11'd1);
        queue_item(FUNC_OFFER, 32'h0001_0000, 24'h00_0030, 24'h00_0031);
        queue_item(FUNC_OFFER, 32'h0009_0000, 24'h00_0032, 24'h00_0033);
        queue_item(FUNC_CLEAR, 32'h0, 24'h0, 24'h0);

        // random phases over a spread of small capacities and one at full depth
        for (ph = 0; ph < 9; ph++) begin
            case (ph)
                0: cap = 11'd1;
                1: cap = 11'd2;
                2: cap = 11'd4;
                3: cap = 11'd7;
                4: cap = 11'd16;
                5: cap = 11'd33;
                6: cap = CNT_W'($urandom_range(1, 64));
                7: cap = CNT_W'($urandom_range(65, 200));
                default: cap = CAP_RESET;
            endcase
            write_capacity(cap);
            sender_steady = ($urandom_range(0, 3) == 0);
            k = $urandom_range(50, 85);
            repeat (9) queue_random(k);
        end

        // oversized capacity saturates: fill to full depth, then churn the root
        write_capacity(11'h7FF);
        sender_steady = 1'b0;
        queue_item(FUNC_CLEAR, 32'h0, 24'h0, 24'h0);
        repeat (1030)
            queue_item(FUNC_OFFER, pick_value(), INDEX_W'($urandom), INDEX_W'($urandom));
        repeat (16) queue_random(50);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("drove %0d offers, %0d pops, %0d clears and %0d unused codes",
                 n_offers, n_pops, n_clears, n_nops);
        $display("capacities 0 to 2047, %0d offers turned away, %0d pops on empty, peak fill %0d",
                 rejected_offers, empty_pops, peak_fill);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count, results_pending);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: bounded_top_k_min_heap.f
rtl/btk_pkg.sv
rtl/btk_ram.sv
rtl/bounded_top_k_min_heap.sv
tb/top_k_heap_checker.sv
tb/bounded_top_k_min_heap_tb.sv
